[src/spjq_pkg.sv]
`timescale 1ns / 1ps
package spjq_pkg;

	localparam int ID_W  = 16;
	localparam int PRI_W = 8;
	localparam int CMD_W = 2;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_LIST
	} op_code_t;

	typedef struct packed {
		op_code_t           code;
		logic [ID_W-1:0]    id;
		logic [PRI_W-1:0]   pri;
	} op_t;

endpackage

[src/sorted_priority_job_queue_core.sv]
`timescale 1ns / 1ps
// Path: an input transfer passes the input register, the op queue and the result register
// on its way to its first result, and waits longer while the op queue holds earlier work.
// Ops: insert and remove each update the sorted register array as the op is taken;
// a listing returns one result per held job, paced by the back end's list counter.
// Reset: arst_n clears the job count, queue pointers and valid flags at once;
// job contents are undefined until written and never read before that.
module sorted_priority_job_queue_core #(
	parameter int DEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [spjq_pkg::CMD_W-1:0]  cmd,
	input  logic [spjq_pkg::ID_W-1:0]   job_id,
	input  logic [spjq_pkg::PRI_W-1:0]  job_priority,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [spjq_pkg::ID_W-1:0]   out_id,
	output logic [spjq_pkg::PRI_W-1:0]  out_priority,
	output logic [spjq_pkg::ST_W-1:0]   status,
	output logic                        last
);
	import spjq_pkg::*;

	logic push_valid;
	logic push_ready;
	op_t  push_op;
	logic pop_valid;
	logic pop;
	op_t  pop_op;

	spjq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.job_id       (job_id),
		.job_priority (job_priority),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_op      (push_op)
	);

	spjq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_op     (pop_op)
	);

	spjq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (pop_valid),
		.op           (pop_op),
		.op_pop       (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_id       (out_id),
		.out_priority (out_priority),
		.status       (status),
		.last         (last)
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
		else $error("undefined status code on result");

	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last && (out_id == '0) && (out_priority == '0))
		else $error("error result carries job data or is not final");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("back end took an op from an empty queue");

endmodule

[src/spjq_front.sv]
`timescale 1ns / 1ps
module spjq_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [spjq_pkg::CMD_W-1:0] cmd,
	input  logic [spjq_pkg::ID_W-1:0]  job_id,
	input  logic [spjq_pkg::PRI_W-1:0] job_priority,
	output logic                      push_valid,
	input  logic                      push_ready,
	output spjq_pkg::op_t             push_op
);
	import spjq_pkg::*;

	logic                 valid_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [ID_W-1:0]      id_s1;
	logic [PRI_W-1:0]     pri_s1;
	logic                 is_op;
	logic                 accept;
	op_code_t             code;

	// unused command code is dropped here, it has no effect and no result
	assign is_op      = (cmd_s1 == CMD_INSERT) || (cmd_s1 == CMD_REMOVE) || (cmd_s1 == CMD_LIST);
	assign push_valid = valid_s1 && is_op;
	assign in_stall   = push_valid && !push_ready;
	assign accept     = in_valid && !in_stall;

	always_comb begin
		case (cmd_s1)
			CMD_INSERT: code = OP_INSERT;
			CMD_REMOVE: code = OP_REMOVE;
			default:    code = OP_LIST;
		endcase
	end

	assign push_op = '{code: code, id: id_s1, pri: pri_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!in_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			id_s1  <= job_id;
			pri_s1 <= job_priority;
		end
	end

endmodule

[src/spjq_queue.sv]
`timescale 1ns / 1ps
module spjq_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  spjq_pkg::op_t push_op,
	output logic          pop_valid,
	input  logic          pop,
	output spjq_pkg::op_t pop_op
);
	import spjq_pkg::*;

	op_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QLVL_W-1:0]   level_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (level_q != QLVL_W'(QUEUE_DEPTH));
	assign pop_valid  = (level_q != '0);
	assign pop_op     = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

[src/spjq_back.sv]
`timescale 1ns / 1ps
module spjq_back #(
	parameter int DEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        op_valid,
	input  spjq_pkg::op_t               op,
	output logic                        op_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [spjq_pkg::ID_W-1:0]   out_id,
	output logic [spjq_pkg::PRI_W-1:0]  out_priority,
	output logic [spjq_pkg::ST_W-1:0]   status,
	output logic                        last
);
	import spjq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [ID_W-1:0]  ids_q  [DEPTH];
	logic [PRI_W-1:0] pris_q [DEPTH];
	logic [ID_W-1:0]  ids_d  [DEPTH];
	logic [PRI_W-1:0] pris_d [DEPTH];
	logic [DEPTH-1:0] gt;
	logic [CW-1:0]    count_q;
	logic [IW-1:0]    list_idx_q;
	logic             out_valid_q;
	logic [ID_W-1:0]  out_id_q;
	logic [PRI_W-1:0] out_pri_q;
	logic [ST_W-1:0]  status_q;
	logic             last_q;
	logic             fire;
	logic             full;
	logic             empty;
	logic             list_last;
	logic             do_insert;
	logic             do_remove;
	logic             shift_k;
	logic             place_k;

	assign fire      = op_valid && (!out_valid_q || !out_stall);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign list_last = ((CW'(list_idx_q) + CW'(1)) == count_q);
	assign do_insert = fire && (op.code == OP_INSERT) && !full;
	assign do_remove = fire && (op.code == OP_REMOVE) && !empty;
	// a listing holds its op at the queue head until its final transfer
	assign op_pop    = fire && ((op.code != OP_LIST) || empty || list_last);

	// each held entry compares against the new priority; strict compare keeps
	// equal priorities in arrival order
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			gt[k] = (CW'(k) < count_q) && (pris_q[k] > op.pri);
		end
	end

	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			ids_d[k]  = ids_q[k];
			pris_d[k] = pris_q[k];
			shift_k   = 1'b0;
			place_k   = 1'b0;
			if (do_insert) begin
				shift_k = (k > 0) ? gt[(k > 0) ? k - 1 : 0] : 1'b0;
				place_k = !shift_k && (gt[k] || (CW'(k) == count_q));
				if (shift_k) begin
					ids_d[k]  = ids_q[(k > 0) ? k - 1 : 0];
					pris_d[k] = pris_q[(k > 0) ? k - 1 : 0];
				end else if (place_k) begin
					ids_d[k]  = op.id;
					pris_d[k] = op.pri;
				end
			end else if (do_remove && (k < DEPTH - 1)) begin
				ids_d[k]  = ids_q[(k < DEPTH - 1) ? k + 1 : k];
				pris_d[k] = pris_q[(k < DEPTH - 1) ? k + 1 : k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DEPTH; k++) begin
			ids_q[k]  <= ids_d[k];
			pris_q[k] <= pris_d[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			list_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + 1'b1;
			end else if (do_remove) begin
				count_q <= count_q - 1'b1;
			end
			if (fire && (op.code == OP_LIST) && !empty) begin
				list_idx_q <= list_last ? '0 : list_idx_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_id_q  <= '0;
			out_pri_q <= '0;
			status_q  <= ST_OK;
			last_q    <= 1'b1;
			case (op.code)
				OP_INSERT: begin
					if (full) begin
						status_q <= ST_FULL;
					end
				end
				OP_REMOVE: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						out_id_q  <= ids_q[0];
						out_pri_q <= pris_q[0];
					end
				end
				OP_LIST: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						out_id_q  <= ids_q[list_idx_q];
						out_pri_q <= pris_q[list_idx_q];
						last_q    <= list_last;
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_id       = out_id_q;
	assign out_priority = out_pri_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule
